@@ src/twrb_pkg.sv @@
package twrb_pkg;

  localparam int TIME_W  = 32;
  localparam int CNT_W   = 8;
  localparam int OCC_W   = 7;
  localparam int LIMIT_W = 7;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_FLUSH   = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROC_WIN  = 2'd0,
    CFG_CLUST_WIN = 2'd1,
    CFG_HIT_LIMIT = 2'd2
  } cfg_idx_t;

  // key_time: hit time for add, new window end for advance
  // aux_time: candidate window end for add, new window start for advance
  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] key_time;
    logic [TIME_W-1:0] aux_time;
  } cmd_t;

  function automatic logic [TIME_W-1:0] floor_sub(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
    floor_sub = (a > b) ? (a - b) : '0;
  endfunction

endpackage

@@ src/twrb_in_if.sv @@
interface twrb_in_if #(
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic [31:0]             hit_time;
  logic [PAYLOAD_BITS-1:0] hit_payload;
  logic [31:0]             new_window_end;

  modport source (output valid, op, hit_time, hit_payload, new_window_end, input ready);
  modport sink   (input valid, op, hit_time, hit_payload, new_window_end, output ready);
endinterface

@@ src/twrb_out_if.sv @@
interface twrb_out_if #(
  parameter int PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic                    hit_valid;
  logic [31:0]             out_time;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic                    last;
  logic signed [7:0]       count;
  logic [6:0]              occupancy;
  logic                    completable_ready;

  modport source (output valid, hit_valid, out_time, out_payload, last, count, occupancy,
                  completable_ready, input ready);
  modport sink   (input valid, hit_valid, out_time, out_payload, last, count, occupancy,
                  completable_ready, output ready);
endinterface

@@ src/timestamp_window_reorder_buffer_top.sv @@
// sequence: add and advance run the drop step for old hits, then send one status word;
// release runs S_CNT1, S_CNT2, S_CNT3, then emits its words; flush goes straight to emitting
// flow: the back sequencer takes a new item from the queue only once it is back in idle;
// emitting and dropping walk the cell chain one hit per cycle, emitting only while not stalled
// reset: synchronous active-low rst_n empties the buffer and window, hit_limit returns to 64
module timestamp_window_reorder_buffer_top #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [twrb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [twrb_pkg::CFG_W-1:0]       cfg_data,
  twrb_in_if.sink                          in_ch,
  twrb_out_if.source                       out_ch
);
  import twrb_pkg::*;

  localparam int QW = $bits(cmd_t) + PAYLOAD_BITS;

  logic [TIME_W-1:0]       pw_r;
  logic [TIME_W-1:0]       cw_r;
  logic [LIMIT_W-1:0]      lim_r;
  logic                    push_valid;
  logic                    push_ready;
  cmd_t                    push_cmd;
  logic [PAYLOAD_BITS-1:0] push_payload;
  logic                    q_valid;
  logic                    q_pop;
  logic [QW-1:0]           q_data;
  cmd_t                    q_cmd;
  logic [PAYLOAD_BITS-1:0] q_payload;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r  <= '0;
      cw_r  <= '0;
      lim_r <= LIMIT_W'(64);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROC_WIN:  pw_r  <= cfg_data[TIME_W-1:0];
        CFG_CLUST_WIN: cw_r  <= cfg_data[TIME_W-1:0];
        CFG_HIT_LIMIT: lim_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  twrb_front #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_front (
    .in_ch        (in_ch),
    .proc_win     (pw_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd),
    .push_payload (push_payload)
  );

  twrb_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_cmd, push_payload}),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  assign q_cmd     = q_data[QW-1:PAYLOAD_BITS];
  assign q_payload = q_data[PAYLOAD_BITS-1:0];

  twrb_back #(.DEPTH(DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .q_payload (q_payload),
    .clust_win (cw_r),
    .hit_limit (lim_r),
    .out_ch    (out_ch)
  );

endmodule

@@ src/twrb_front.sv @@
module twrb_front #(
  parameter int PAYLOAD_BITS = 32
) (
  twrb_in_if.sink                      in_ch,
  input  logic [twrb_pkg::TIME_W-1:0]  proc_win,
  output logic                         push_valid,
  input  logic                         push_ready,
  output twrb_pkg::cmd_t               push_cmd,
  output logic [PAYLOAD_BITS-1:0]      push_payload
);
  import twrb_pkg::*;

  op_t op;

  always_comb begin
    op = op_t'(in_ch.op);
    push_cmd.op = op;
    case (op)
      OP_ADD: begin
        push_cmd.key_time = in_ch.hit_time;
        // wraps modulo 2^32 on purpose
        push_cmd.aux_time = in_ch.hit_time + proc_win;
      end
      OP_ADVANCE: begin
        push_cmd.key_time = in_ch.new_window_end;
        push_cmd.aux_time = floor_sub(in_ch.new_window_end, proc_win);
      end
      default: begin
        push_cmd.key_time = '0;
        push_cmd.aux_time = '0;
      end
    endcase
  end

  assign push_valid   = in_ch.valid;
  assign push_payload = in_ch.hit_payload;
  assign in_ch.ready  = push_ready;

endmodule

@@ src/twrb_queue.sv @@
module twrb_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;
  logic             do_push;

  assign push_ready = (fill_r != 2'd2);
  assign pop_valid  = (fill_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + {1'b0, do_push} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r != 2'd3)
    else $error("queue fill out of range");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> pop_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (fill_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree when empty");

endmodule

@@ src/twrb_back.sv @@
module twrb_back #(
  parameter int DEPTH        = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  twrb_pkg::cmd_t               q_cmd,
  input  logic [PAYLOAD_BITS-1:0]      q_payload,
  input  logic [twrb_pkg::TIME_W-1:0]  clust_win,
  input  logic [twrb_pkg::LIMIT_W-1:0] hit_limit,
  twrb_out_if.source                   out_ch
);
  import twrb_pkg::*;

  localparam int HW = $clog2(DEPTH + 1);
  localparam int NG = (DEPTH + 7) / 8;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CNT1 = 6'b000010,
    S_CNT2 = 6'b000100,
    S_CNT3 = 6'b001000,
    S_DROP = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t state_r;

  // sorted cell chain, oldest hit in cell 0
  logic [TIME_W-1:0]       time_r [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_r  [DEPTH];

  logic [HW-1:0]           held_r;
  logic [TIME_W-1:0]       ws_r;
  logic [TIME_W-1:0]       we_r;
  logic [TIME_W-1:0]       latest_r;
  logic [TIME_W-1:0]       cutoff_r;
  logic signed [CNT_W-1:0] cnt_r;
  logic [HW-1:0]           rem_r;
  logic [HW-1:0]           occfin_r;
  op_t                     opq_r;
  logic [NG*8-1:0]         flags_r;
  logic [3:0]              part_r [NG];

  logic                    o_valid_r;
  logic                    o_hit_r;
  logic [TIME_W-1:0]       o_time_r;
  logic [PAYLOAD_BITS-1:0] o_pay_r;
  logic                    o_last_r;
  logic signed [CNT_W-1:0] o_cnt_r;
  logic [OCC_W-1:0]        o_occ_r;
  logic                    o_rdy_r;

  logic [TIME_W-1:0]  cmp_val;
  logic [TIME_W-1:0]  cut_now;
  logic [DEPTH-1:0]   gtv;
  logic [DEPTH-1:0]   gtv_prev;
  logic [NG*8-1:0]    rel_flags;
  logic [LIMIT_W-1:0] lim_eff;
  logic               room;
  logic               move;
  logic [TIME_W-1:0]  ws_a;
  logic [TIME_W-1:0]  we_a;
  logic               ins;
  logic               do_ins;
  logic               do_shift;
  logic               head_old;
  logic               head_rel;
  logic               out_free;
  logic               o_load;
  logic [HW-1:0]      rel_sum;

  always_comb begin
    cmp_val = (state_r == S_IDLE) ? q_cmd.key_time : cutoff_r;
    cut_now = floor_sub(latest_r, clust_win);
    gtv_prev = '0;
    rel_flags = '0;
    for (int i = 0; i < DEPTH; i++) begin
      gtv[i] = (HW'(i) < held_r) && (time_r[i] > cmp_val);
    end
    for (int i = 1; i < DEPTH; i++) begin
      gtv_prev[i] = gtv[i-1];
    end
    for (int i = 0; i < DEPTH; i++) begin
      rel_flags[i] = (HW'(i) < held_r) && !gtv[i];
    end
    lim_eff = (hit_limit > LIMIT_W'(DEPTH)) ? LIMIT_W'(DEPTH) : hit_limit;
    room    = LIMIT_W'(held_r) < lim_eff;
    move    = (held_r == '0) || (q_cmd.key_time > we_r);
    ws_a    = move ? q_cmd.key_time : ws_r;
    we_a    = move ? q_cmd.aux_time : we_r;
    ins     = room && (q_cmd.key_time >= ws_a) && (q_cmd.key_time <= we_a);
    q_pop   = (state_r == S_IDLE) && q_valid;
    do_ins  = q_pop && (q_cmd.op == OP_ADD) && ins;
    head_old = (held_r != '0) && (time_r[0] < ws_r);
    head_rel = (time_r[0] <= cutoff_r);
    out_free = !o_valid_r || out_ch.ready;
    o_load   = out_free && (((state_r == S_DROP) && !head_old) || (state_r == S_EMIT));
    do_shift = ((state_r == S_DROP) && head_old) ||
               ((state_r == S_EMIT) && out_free && (rem_r != '0));
    rel_sum = '0;
    for (int g = 0; g < NG; g++) begin
      rel_sum = rel_sum + HW'(part_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (do_ins) begin
      if (gtv[0] || (held_r == '0)) begin
        time_r[0] <= q_cmd.key_time;
        pay_r[0]  <= q_payload;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (gtv_prev[i]) begin
          time_r[i] <= time_r[i-1];
          pay_r[i]  <= pay_r[i-1];
        end else if (gtv[i] || (HW'(i) == held_r)) begin
          time_r[i] <= q_cmd.key_time;
          pay_r[i]  <= q_payload;
        end
      end
    end else if (do_shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        time_r[i] <= time_r[i+1];
        pay_r[i]  <= pay_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CNT1) begin
      flags_r <= rel_flags;
    end
    if (state_r == S_CNT2) begin
      for (int g = 0; g < NG; g++) begin
        part_r[g] <= 4'($countones(flags_r[g*8 +: 8]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      held_r    <= '0;
      ws_r      <= '0;
      we_r      <= '0;
      latest_r  <= '0;
      o_valid_r <= 1'b0;
    end else begin
      if (o_valid_r && out_ch.ready && !o_load) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            opq_r <= q_cmd.op;
            case (q_cmd.op)
              OP_ADD: begin
                if (room) begin
                  ws_r <= ws_a;
                  we_r <= we_a;
                end
                if (ins) begin
                  held_r <= held_r + 1'b1;
                  if ((held_r == '0) || (q_cmd.key_time >= latest_r)) begin
                    latest_r <= q_cmd.key_time;
                  end
                end
                cnt_r   <= ins ? CNT_W'(1) : '0;
                state_r <= S_DROP;
              end
              OP_ADVANCE: begin
                we_r     <= q_cmd.key_time;
                ws_r     <= q_cmd.aux_time;
                cutoff_r <= cut_now;
                cnt_r    <= '0;
                state_r  <= S_DROP;
              end
              OP_RELEASE: begin
                cutoff_r <= cut_now;
                state_r  <= S_CNT1;
              end
              default: begin
                ws_r     <= '0;
                we_r     <= '0;
                rem_r    <= held_r;
                occfin_r <= '0;
                state_r  <= S_EMIT;
              end
            endcase
          end
        end
        S_CNT1: state_r <= S_CNT2;
        S_CNT2: state_r <= S_CNT3;
        S_CNT3: begin
          rem_r    <= rel_sum;
          occfin_r <= held_r - rel_sum;
          state_r  <= S_EMIT;
        end
        S_DROP: begin
          if (head_old) begin
            held_r <= held_r - 1'b1;
            // on advance, only old hits that were releasable lower the releasable count
            if ((opq_r == OP_ADVANCE) && head_rel) cnt_r <= cnt_r - 1'b1;
          end else if (out_free) begin
            o_valid_r <= 1'b1;
            o_hit_r   <= 1'b0;
            o_time_r  <= '0;
            o_pay_r   <= '0;
            o_last_r  <= 1'b1;
            o_cnt_r   <= cnt_r;
            o_occ_r   <= OCC_W'(held_r);
            o_rdy_r   <= (held_r != '0) && (time_r[0] <= cut_now);
            state_r   <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            o_valid_r <= 1'b1;
            o_cnt_r   <= '0;
            o_occ_r   <= OCC_W'(occfin_r);
            o_rdy_r   <= 1'b0;
            if (rem_r == '0) begin
              o_hit_r  <= 1'b0;
              o_time_r <= '0;
              o_pay_r  <= '0;
              o_last_r <= 1'b1;
              state_r  <= S_IDLE;
            end else begin
              o_hit_r  <= 1'b1;
              o_time_r <= time_r[0];
              o_pay_r  <= pay_r[0];
              o_last_r <= (rem_r == HW'(1));
              held_r   <= held_r - 1'b1;
              rem_r    <= rem_r - 1'b1;
              if (rem_r == HW'(1)) state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = o_valid_r;
  assign out_ch.hit_valid         = o_hit_r;
  assign out_ch.out_time          = o_time_r;
  assign out_ch.out_payload       = o_pay_r;
  assign out_ch.last              = o_last_r;
  assign out_ch.count             = o_cnt_r;
  assign out_ch.occupancy         = o_occ_r;
  assign out_ch.completable_ready = o_rdy_r;

  assert property (@(posedge clk) disable iff (!rst_n) held_r <= HW'(DEPTH))
    else $error("held count above depth");
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_EMIT) |-> (rem_r <= held_r))
    else $error("more words to emit than hits held");
  assert property (@(posedge clk) disable iff (!rst_n)
                   q_pop |=> (state_r != S_IDLE))
    else $error("popped item not processed");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import twrb_pkg::*;

  localparam int DEPTH = 64;

  typedef struct {
    logic        hit_valid;
    logic [31:0] out_time;
    logic [31:0] out_payload;
    logic        last;
    logic [7:0]  count;
    logic [6:0]  occupancy;
    logic        completable_ready;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  twrb_in_if  #(.PAYLOAD_BITS(32)) in_ch ();
  twrb_out_if #(.PAYLOAD_BITS(32)) out_ch ();

  timestamp_window_reorder_buffer_top #(.DEPTH(DEPTH), .PAYLOAD_BITS(32)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #2 clk = ~clk;

  // shadow of the buffer contents and settings
  logic [31:0] sh_time [DEPTH];
  logic [31:0] sh_pay [DEPTH];
  int unsigned sh_held;
  logic [31:0] sh_wstart, sh_wend;
  logic [31:0] sh_proc_win, sh_clust_win;
  logic [6:0]  sh_limit;

  word_t expected_words[$];
  int errors = 0;
  int words_seen = 0;
  int items_sent = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD;
    in_ch.hit_time = '0;
    in_ch.hit_payload = '0;
    in_ch.new_window_end = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int unsigned count_releasable();
    logic [31:0] cutoff;
    int unsigned n;
    n = 0;
    if (sh_held == 0) return 0;
    cutoff = (sh_time[sh_held-1] > sh_clust_win) ? sh_time[sh_held-1] - sh_clust_win : '0;
    while (n < sh_held && sh_time[n] <= cutoff) n++;
    return n;
  endfunction

  function automatic void remove_front(int unsigned n);
    if (n > sh_held) n = sh_held;
    for (int unsigned i = 0; i + n < sh_held; i++) begin
      sh_time[i] = sh_time[i+n];
      sh_pay[i] = sh_pay[i+n];
    end
    sh_held -= n;
  endfunction

  function automatic void drop_stale();
    int unsigned n;
    n = 0;
    while (n < sh_held && sh_time[n] < sh_wstart) n++;
    remove_front(n);
  endfunction

  function automatic void queue_word(logic hv, logic [31:0] t, logic [31:0] p, logic lst,
                                     logic [7:0] cnt);
    word_t w;
    w.hit_valid = hv;
    w.out_time = t;
    w.out_payload = p;
    w.last = lst;
    w.count = cnt;
    w.occupancy = sh_held[6:0];
    w.completable_ready = count_releasable() > 0;
    expected_words.push_back(w);
  endfunction

  function automatic void predict_reorder(op_t op, logic [31:0] t, logic [31:0] p,
                                          logic [31:0] ne);
    int unsigned lim, pos, n, rel_pre, rel_post;
    logic [31:0] tt [DEPTH];
    logic [31:0] pp [DEPTH];
    logic added;
    case (op)
      OP_ADD: begin
        lim = (sh_limit > DEPTH) ? DEPTH : sh_limit;
        added = 1'b0;
        if (sh_held < lim) begin
          if (sh_held == 0 || t > sh_wend) begin
            sh_wstart = t;
            sh_wend = t + sh_proc_win;
          end
          if (t >= sh_wstart && t <= sh_wend) begin
            pos = 0;
            while (pos < sh_held && sh_time[pos] <= t) pos++;
            for (int unsigned i = sh_held; i > pos; i--) begin
              sh_time[i] = sh_time[i-1];
              sh_pay[i] = sh_pay[i-1];
            end
            sh_time[pos] = t;
            sh_pay[pos] = p;
            sh_held++;
            added = 1'b1;
          end
        end
        drop_stale();
        queue_word(1'b0, '0, '0, 1'b1, {7'd0, added});
      end
      OP_ADVANCE: begin
        rel_pre = count_releasable();
        sh_wend = ne;
        sh_wstart = (ne > sh_proc_win) ? ne - sh_proc_win : '0;
        drop_stale();
        rel_post = count_releasable();
        queue_word(1'b0, '0, '0, 1'b1, 8'(rel_post - rel_pre));
      end
      default: begin
        n = (op == OP_RELEASE) ? count_releasable() : sh_held;
        for (int unsigned i = 0; i < n; i++) begin
          tt[i] = sh_time[i];
          pp[i] = sh_pay[i];
        end
        if (op == OP_RELEASE) begin
          remove_front(n);
        end else begin
          sh_held = 0;
          sh_wstart = '0;
          sh_wend = '0;
        end
        if (n == 0) queue_word(1'b0, '0, '0, 1'b1, 8'd0);
        for (int unsigned i = 0; i < n; i++)
          queue_word(1'b1, tt[i], pp[i], i + 1 == n, 8'd0);
      end
    endcase
  endfunction

  // result side: random stall, compare each accepted word
  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("unexpected word: time %0h payload %0h", out_ch.out_time, out_ch.out_payload);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_ch.hit_valid !== w.hit_valid) begin
          $error("hit_valid: expected %0d actual %0d", w.hit_valid, out_ch.hit_valid);
          errors++;
        end
        if (out_ch.out_time !== w.out_time) begin
          $error("out_time: expected %0h actual %0h", w.out_time, out_ch.out_time);
          errors++;
        end
        if (out_ch.out_payload !== w.out_payload) begin
          $error("out_payload: expected %0h actual %0h", w.out_payload, out_ch.out_payload);
          errors++;
        end
        if (out_ch.last !== w.last) begin
          $error("last: expected %0d actual %0d", w.last, out_ch.last);
          errors++;
        end
        if (out_ch.count !== w.count) begin
          $error("count: expected %0d actual %0d", $signed(w.count), out_ch.count);
          errors++;
        end
        if (out_ch.occupancy !== w.occupancy) begin
          $error("occupancy: expected %0d actual %0d", w.occupancy, out_ch.occupancy);
          errors++;
        end
        if (out_ch.completable_ready !== w.completable_ready) begin
          $error("completable_ready: expected %0d actual %0d", w.completable_ready,
                 out_ch.completable_ready);
          errors++;
        end
      end
    end
  end

  // valid stays up after the accept; the next call replaces the item or takes it down, a drain takes it down
  task automatic send_item(op_t op, logic [31:0] t, logic [31:0] p, logic [31:0] ne);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.hit_time <= t;
    in_ch.hit_payload <= p;
    in_ch.new_window_end <= ne;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_reorder(op, t, p, ne);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_words();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    // idle margin before settings change
    repeat (DEPTH + 10) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      CFG_PROC_WIN:  sh_proc_win = val;
      CFG_CLUST_WIN: sh_clust_win = val;
      default:       sh_limit = val[6:0];
    endcase
  endtask

  task automatic set_windows(logic [31:0] pw, logic [31:0] cw, logic [6:0] lim);
    drain_words();
    write_reg(CFG_PROC_WIN, pw);
    write_reg(CFG_CLUST_WIN, cw);
    write_reg(CFG_HIT_LIMIT, {25'd0, lim});
    cfg_we <= 1'b0;
  endtask

  task automatic test_directed();
    set_windows(32'd100, 32'd10, 7'd64);
    send_item(OP_RELEASE, '0, '0, '0);             // empty release
    send_item(OP_FLUSH, '0, '0, '0);               // empty flush
    send_item(OP_ADD, 32'd50, 32'hFFFF_FFFF, '0);
    send_item(OP_ADD, 32'd50, 32'h0000_0001, '0);  // equal time keeps order
    send_item(OP_ADD, 32'd40, 32'h1234_5678, '0);  // below window start
    send_item(OP_ADD, 32'd150, 32'hA5A5_A5A5, '0);
    send_item(OP_ADD, 32'd149, 32'h5A5A_5A5A, '0);
    send_item(OP_ADD, 32'd151, 32'h0, '0);         // past end, window moves
    send_item(OP_RELEASE, '0, '0, '0);
    send_item(OP_ADVANCE, '0, '0, 32'd400);
    send_item(OP_ADVANCE, '0, '0, 32'd30);         // start floors at zero
    send_item(OP_ADD, 32'hFFFF_FFF0, 32'h8000_0000, '0); // end wraps
    send_item(OP_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0);
    send_item(OP_FLUSH, '0, '0, '0);
    set_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0); // zero limit
    send_item(OP_ADD, 32'd5, 32'd5, '0);
    send_item(OP_ADVANCE, '0, '0, 32'hFFFF_FFFF);
    set_windows(32'd0, 32'd0, 7'd127);             // limit above depth
    send_item(OP_ADD, 32'd7, 32'd1, '0);
    send_item(OP_ADD, 32'd7, 32'd2, '0);
    send_item(OP_RELEASE, '0, '0, '0);
    send_item(OP_FLUSH, '0, '0, '0);
  endtask

  task automatic test_fill_limit();
    logic [31:0] base;
    base = $urandom;
    set_windows(32'd1000, 32'd0, 7'd64);
    send_item(OP_ADD, base & 32'h0FFF_FFFF, $urandom, '0);
    for (int i = 0; i < 66; i++)
      send_item(OP_ADD, (base & 32'h0FFF_FFFF) + $urandom_range(1000), $urandom, '0);
    send_item(OP_RELEASE, '0, '0, '0);             // all 64 words
    set_windows(32'd0, 32'd0, 7'd3);
    for (int i = 0; i < 5; i++) send_item(OP_ADD, 32'd9, $urandom, '0);
    send_item(OP_FLUSH, '0, '0, '0);
  endtask

  task automatic test_random(int n, int pin, int pout);
    logic [31:0] base, t;
    int r;
    in_idle_pct = pin;
    out_idle_pct = pout;
    set_windows($urandom_range(200), $urandom_range(60), 7'($urandom_range(2, 40)));
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      t = base + $urandom_range(250);
      if (r < 60) send_item(OP_ADD, (r < 3) ? $urandom : t, $urandom, '0);
      else if (r < 78) send_item(OP_RELEASE, $urandom, $urandom, $urandom);
      else if (r < 84) begin
        send_item(OP_FLUSH, '0, '0, '0);
        base = $urandom;
      end else send_item(OP_ADVANCE, '0, $urandom, (r < 88) ? $urandom : t);
      if (i == n / 2) drain_words();              // sender holds until all words return
    end
    send_item(OP_FLUSH, '0, '0, '0);
  endtask

  initial begin
    sh_held = 0;
    sh_wstart = '0;
    sh_wend = '0;
    sh_proc_win = '0;
    sh_clust_win = '0;
    sh_limit = 7'd64;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_fill_limit();
    test_random(8, 6, 72);
    test_random(8, 72, 6);
    test_random(8, 0, 0);
    drain_words();
    $display("ran %0d items, checked %0d words over add, release, flush and advance",
             items_sent, words_seen);
    $display("settings swept window lengths 0 to max and hit limits 0, 3, 64, 127");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule

@@ files.f @@
src/twrb_pkg.sv
src/twrb_in_if.sv
src/twrb_out_if.sv
src/twrb_front.sv
src/twrb_queue.sv
src/twrb_back.sv
src/timestamp_window_reorder_buffer_top.sv
verif/tb_top.sv
